>>> sv/terminated_line_decimal_parser_defines.svh
// Assertion macros shared by the checker files.
// No dependencies; included by tldp_chk.sv.
`ifndef TERMINATED_LINE_DECIMAL_PARSER_DEFINES_SVH
`define TERMINATED_LINE_DECIMAL_PARSER_DEFINES_SVH

// cond must hold at every edge out of reset
`define TLDP_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("tldp: check failed");

// post must hold at the next edge after pre
`define TLDP_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("tldp: check failed");

// post must hold at the same edge as pre
`define TLDP_ASSERT_SAME(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("tldp: check failed");

`endif

>>> sv/tldp_pkg.sv
// Types and constants of the line parser.
// No dependencies; used by tldp_chan_if, tldp_front, tldp_fifo, tldp_back and the top level.
package tldp_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned ValueW = 32;
	localparam int unsigned LenW   = 5;
	localparam int unsigned DigitW = 4;

	localparam logic [ByteW-1:0] CharPlus   = 8'h2B;
	localparam logic [ByteW-1:0] CharMinus  = 8'h2D;
	localparam logic [ByteW-1:0] CharZero   = 8'h30;
	localparam logic [ByteW-1:0] CharNine   = 8'h39;
	localparam logic [ByteW-1:0] TermResetC = 8'h0A;

	// register select, taken from paddr[2]
	localparam logic RegFirstTerm  = 1'b0;
	localparam logic RegSecondTerm = 1'b1;

	typedef enum logic [2:0] {
		OP_SIGN_NEG,
		OP_SIGN_POS,
		OP_DIGIT,
		OP_OTHER,
		OP_EMIT,
		OP_DROP
	} tldp_op_t;

	typedef struct packed {
		tldp_op_t          op;
		logic [DigitW-1:0] digit;
		logic [LenW-1:0]   len;
	} tldp_entry_t;

	typedef struct packed {
		logic        valid;
		tldp_entry_t entry;
	} tldp_push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} tldp_fifo_stat_t;

endpackage

>>> sv/tldp_chan_if.sv
// Handshake channels of the line parser: byte input and result output.
// Depends on tldp_pkg.
interface tldp_byte_if;
	import tldp_pkg::*;
	logic             valid;
	logic             ready;
	logic [ByteW-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tldp_result_if;
	import tldp_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [ValueW-1:0] parsed_value;
	logic [LenW-1:0]          line_length;

	modport source (output valid, output parsed_value, output line_length, input ready);
	modport sink   (input valid, input parsed_value, input line_length, output ready);
endinterface

>>> sv/tldp_front.sv
// Front end: takes bytes, frames lines, classifies each byte but the first terminator into a queue op.
// Depends on tldp_pkg and tldp_chan_if.
module tldp_front #(
	parameter int unsigned MAX_LINE = 10
) (
	input  logic                      clk,
	input  logic                      arst_n,
	tldp_byte_if.sink                 rx,
	input  logic [tldp_pkg::ByteW-1:0] first_term,
	input  logic [tldp_pkg::ByteW-1:0] second_term,
	input  tldp_pkg::tldp_fifo_stat_t fifo_stat,
	output tldp_pkg::tldp_push_t      push
);
	import tldp_pkg::*;

	localparam logic [LenW-1:0] MaxLineC = LenW'(MAX_LINE);

	logic [LenW-1:0] count_q;
	logic            seen_q;
	logic            accept;
	logic [LenW-1:0] count_inc;
	logic            is_digit;
	logic            is_sign;

	assign rx.ready  = !fifo_stat.full;
	assign accept    = rx.valid && rx.ready;
	assign count_inc = count_q + LenW'(1);
	assign is_digit  = (rx.rx_byte >= CharZero) && (rx.rx_byte <= CharNine);
	assign is_sign   = (rx.rx_byte == CharMinus) || (rx.rx_byte == CharPlus);

	always_comb begin
		push.valid       = 1'b0;
		push.entry.op    = OP_OTHER;
		push.entry.digit = DigitW'(rx.rx_byte - CharZero);
		push.entry.len   = count_q;
		if (accept) begin
			if (seen_q) begin
				push.valid    = 1'b1;
				push.entry.op = (rx.rx_byte == second_term) ? OP_EMIT : OP_DROP;
			end else if (rx.rx_byte != first_term) begin
				push.valid = 1'b1;
				if (count_inc >= MaxLineC) begin
					push.entry.op = OP_DROP;
				end else if (count_q == '0 && is_sign) begin
					push.entry.op = (rx.rx_byte == CharMinus) ? OP_SIGN_NEG : OP_SIGN_POS;
				end else if (is_digit) begin
					push.entry.op = OP_DIGIT;
				end else begin
					push.entry.op = OP_OTHER;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			seen_q  <= 1'b0;
		end else if (accept) begin
			if (seen_q) begin
				count_q <= '0;
				seen_q  <= 1'b0;
			end else if (rx.rx_byte == first_term) begin
				seen_q <= 1'b1;
			end else if (count_inc >= MaxLineC) begin
				count_q <= '0;
			end else begin
				count_q <= count_inc;
			end
		end
	end

endmodule

>>> sv/tldp_fifo.sv
// Two-entry queue of classified ops between front and back end.
// Depends on tldp_pkg.
module tldp_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tldp_pkg::tldp_push_t      push,
	input  logic                      pop,
	output tldp_pkg::tldp_fifo_stat_t stat,
	output tldp_pkg::tldp_entry_t     head
);
	import tldp_pkg::*;

	localparam int unsigned Depth = 2;
	localparam int unsigned PtrW  = $clog2(Depth);

	tldp_entry_t     mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [PtrW:0]   cnt_q;
	logic            do_pop;

	assign stat.full  = (cnt_q == (PtrW+1)'(Depth));
	assign stat.empty = (cnt_q == '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_pop     = pop && !stat.empty;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			case ({push.valid, do_pop})
				2'b10:   cnt_q <= cnt_q + (PtrW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (PtrW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> sv/tldp_back.sv
// Back end: applies queued ops to the running value and holds the result word.
// Depends on tldp_pkg and tldp_chan_if.
module tldp_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tldp_pkg::tldp_fifo_stat_t fifo_stat,
	input  tldp_pkg::tldp_entry_t     head,
	output logic                      pop,
	tldp_result_if.source             res
);
	import tldp_pkg::*;

	logic [ValueW-1:0]        acc_q;
	logic                     neg_q;
	logic                     stop_q;
	logic                     valid_q;
	logic signed [ValueW-1:0] value_q;
	logic [LenW-1:0]          len_q;
	logic [ValueW-1:0]        acc_x10;
	logic [ValueW-1:0]        signed_acc;

	// x10 as x8 + x2, then the digit
	assign acc_x10    = {acc_q[ValueW-4:0], 3'b000} + {acc_q[ValueW-2:0], 1'b0}
		+ ValueW'(head.digit);
	assign signed_acc = neg_q ? (ValueW'(0) - acc_q) : acc_q;
	assign pop        = !fifo_stat.empty && (head.op != OP_EMIT || !valid_q || res.ready);

	assign res.valid        = valid_q;
	assign res.parsed_value = value_q;
	assign res.line_length  = len_q;

	always_ff @(posedge clk) begin
		if (pop && head.op == OP_EMIT) begin
			value_q <= $signed(signed_acc);
			len_q   <= head.len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			neg_q   <= 1'b0;
			stop_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (pop && head.op == OP_EMIT) begin
				valid_q <= 1'b1;
			end else if (res.ready) begin
				valid_q <= 1'b0;
			end
			if (pop) begin
				case (head.op)
					OP_SIGN_NEG: neg_q <= 1'b1;
					OP_SIGN_POS: neg_q <= 1'b0;
					OP_DIGIT: begin
						if (!stop_q) begin
							acc_q <= acc_x10;
						end
					end
					OP_OTHER: stop_q <= 1'b1;
					OP_EMIT, OP_DROP: begin
						acc_q  <= '0;
						neg_q  <= 1'b0;
						stop_q <= 1'b0;
					end
					default: acc_q <= acc_q;
				endcase
			end
		end
	end

endmodule

>>> sv/terminated_line_decimal_parser.sv
// Top level of the line-terminated decimal parser: config registers and wiring.
// Depends on tldp_pkg, tldp_chan_if, tldp_front, tldp_fifo, tldp_back.
//
//  channel  dir  handshake        payload
//  rx       in   valid / ready    rx_byte [7:0]
//  res      out  valid / ready    parsed_value [31:0] signed, line_length [4:0]
//  apb      in   psel / penable   paddr [2:0], pwdata / prdata [31:0]
//
// One byte per cycle while rx.ready is high. The front end frames each byte in
// the cycle it is taken and queues at most one op; the back end retires one op
// per cycle unless a result word is stalled, through a single x10 shift-add,
// and a result word passes queue and output register. rx.ready drops only when
// the two-entry queue is full, which takes a result word stalled in the output
// register. Reset is async, needs no clearing pass; both terminators reset to LF.
module terminated_line_decimal_parser #(
	parameter int unsigned MAX_LINE = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	tldp_byte_if.sink   rx,
	tldp_result_if.source res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import tldp_pkg::*;

	logic [ByteW-1:0] first_term_q;
	logic [ByteW-1:0] second_term_q;
	logic             reg_sel;
	logic             cfg_wr;
	tldp_push_t       push;
	tldp_fifo_stat_t  fifo_stat;
	tldp_entry_t      head;
	logic             pop;

	// register select is paddr[2]; byte offsets alias
	assign reg_sel = paddr[2];
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = {(32-ByteW)'(0), (reg_sel == RegSecondTerm) ? second_term_q : first_term_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_term_q  <= TermResetC;
			second_term_q <= TermResetC;
		end else if (cfg_wr) begin
			if (reg_sel == RegFirstTerm) begin
				first_term_q <= pwdata[ByteW-1:0];
			end else begin
				second_term_q <= pwdata[ByteW-1:0];
			end
		end
	end

	// framing and byte classes
	tldp_front #(.MAX_LINE(MAX_LINE)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx          (rx),
		.first_term  (first_term_q),
		.second_term (second_term_q),
		.fifo_stat   (fifo_stat),
		.push        (push)
	);

	// decouples framing from arithmetic so each side stalls on its own
	tldp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.stat   (fifo_stat),
		.head   (head)
	);

	// digit accumulate, sign, result word register
	tldp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fifo_stat (fifo_stat),
		.head      (head),
		.pop       (pop),
		.res       (res)
	);

endmodule

>>> sv/tldp_chk.sv
// Port-level checks of the line parser, bound onto the top level.
// Depends on terminated_line_decimal_parser_defines.svh and the top level.
`include "terminated_line_decimal_parser_defines.svh"

module tldp_chk #(
	parameter int unsigned MAX_LINE = 10
) (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] res_value,
	input logic [4:0]  res_len,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready
);

	localparam logic [4:0] MaxLineC = 5'(MAX_LINE);

	`TLDP_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_value) && $stable(res_len))
	`TLDP_ASSERT_ALWAYS(a_pready, clk, arst_n, pready)
	`TLDP_ASSERT_SAME(a_len_bound, clk, arst_n, res_valid, res_len < MaxLineC)
	`TLDP_ASSERT_ALWAYS(a_prdata_hi, clk, arst_n, prdata[31:8] == 24'h0)
	`TLDP_ASSERT_NEXT(a_cfg_readback, clk, arst_n, psel && penable && pwrite, paddr[2] != $past(paddr[2]) || prdata[7:0] == $past(pwdata[7:0]))

endmodule

bind terminated_line_decimal_parser tldp_chk #(.MAX_LINE(MAX_LINE)) u_tldp_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_value (res.parsed_value),
	.res_len   (res.line_length),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata),
	.pready    (pready)
);
